// ----- design/risc16_instruction_execute_unit_macros.svh -----
// Assertion helpers for the execute unit (clk / rst_n in scope).
`ifndef RISC16_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define RISC16_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH

`define R16_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("risc16 implication check failed");

`define R16_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("risc16 next-cycle check failed");

`endif

// ----- design/risc16_pkg.sv -----
`default_nettype none
package risc16_pkg;

    localparam logic [15:0] DSTACK_BASE  = 16'hFFEF;
    localparam logic [15:0] CSTACK_BASE  = 16'hFBEF;
    localparam logic [15:0] CSTACK_LIMIT = 16'hF7EF;
    localparam logic [15:0] PC_CELL      = 16'hFFF0;
    localparam logic [15:0] STATUS_CELL  = 16'hFFF1;
    localparam logic [15:0] PRINT_CELL   = 16'hFFF2;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_EXEC  = 2'd2;

    localparam logic [2:0] FAULT_NONE   = 3'd0;
    localparam logic [2:0] FAULT_DS_OVF = 3'd1;
    localparam logic [2:0] FAULT_DS_UNF = 3'd2;
    localparam logic [2:0] FAULT_CS_OVF = 3'd3;
    localparam logic [2:0] FAULT_CS_UNF = 3'd4;
    localparam logic [2:0] FAULT_DIV0   = 3'd5;

    localparam logic [4:0] OP_LDI  = 5'd1;
    localparam logic [4:0] OP_LD   = 5'd2;
    localparam logic [4:0] OP_ST   = 5'd3;
    localparam logic [4:0] OP_CALL = 5'd4;
    localparam logic [4:0] OP_RET  = 5'd5;
    localparam logic [4:0] OP_PUSH = 5'd6;
    localparam logic [4:0] OP_POP  = 5'd7;
    localparam logic [4:0] OP_MOV  = 5'd8;
    localparam logic [4:0] OP_ADD  = 5'd9;
    localparam logic [4:0] OP_SUB  = 5'd10;
    localparam logic [4:0] OP_MUL  = 5'd11;
    localparam logic [4:0] OP_DIV  = 5'd12;
    localparam logic [4:0] OP_MOD  = 5'd13;
    localparam logic [4:0] OP_INC  = 5'd14;
    localparam logic [4:0] OP_DEC  = 5'd15;
    localparam logic [4:0] OP_SHL  = 5'd16;
    localparam logic [4:0] OP_SHR  = 5'd17;
    localparam logic [4:0] OP_AND  = 5'd18;
    localparam logic [4:0] OP_NAND = 5'd19;
    localparam logic [4:0] OP_OR   = 5'd20;
    localparam logic [4:0] OP_NOR  = 5'd21;
    localparam logic [4:0] OP_XOR  = 5'd22;
    localparam logic [4:0] OP_CMP  = 5'd23;
    localparam logic [4:0] OP_JMP  = 5'd24;
    localparam logic [4:0] OP_JZ   = 5'd25;
    localparam logic [4:0] OP_JNZ  = 5'd26;
    localparam logic [4:0] OP_JS   = 5'd27;
    localparam logic [4:0] OP_JNS  = 5'd28;
    localparam logic [4:0] OP_HALT = 5'd31;

    typedef struct packed {
        logic        we;
        logic [15:0] waddr;
        logic [15:0] wdata;
        logic [15:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic        we;
        logic [2:0]  waddr;
        logic [15:0] wdata;
        logic [2:0]  raddr0;
        logic [2:0]  raddr1;
    } rf_req_t;

    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] quo;
        logic [15:0] rem;
    } div_rsp_t;

endpackage
`default_nettype wire

// ----- design/risc16_mem.sv -----
`default_nettype none
module risc16_mem (
    input  wire logic                clk,
    input  wire risc16_pkg::mem_req_t req,
    output logic [15:0]              rdata
);
    logic [15:0] mem [65536];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ----- design/risc16_regs.sv -----
`default_nettype none
module risc16_regs (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire risc16_pkg::rf_req_t req,
    output logic [15:0]             rdata0,
    output logic [15:0]             rdata1
);
    logic [15:0] rf [8];
    logic [7:0]  valid_reg;
    logic [15:0] rdata0_reg;
    logic [15:0] rdata1_reg;

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.we)
        begin
            valid_reg[req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            rf[req.waddr] <= req.wdata;
        end
        rdata0_reg <= valid_reg[req.raddr0] ? rf[req.raddr0] : 16'd0;
        rdata1_reg <= valid_reg[req.raddr1] ? rf[req.raddr1] : 16'd0;
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;
endmodule
`default_nettype wire

// ----- design/risc16_div.sv -----
`default_nettype none
module risc16_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire risc16_pkg::div_req_t req,
    output risc16_pkg::div_rsp_t      rsp
);
    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] quo_reg;
    logic [15:0] rem_reg;
    logic [15:0] dsr_reg;
    logic [16:0] trial;

    assign trial = {rem_reg, quo_reg[15]} - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd16;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[16])
            begin
                rem_reg <= trial[15:0];
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[14:0], quo_reg[15]};
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;
endmodule
`default_nettype wire

// ----- design/risc16_instruction_execute_unit.sv -----
// An execute request steps through fetch, operand/immediate read, address/data
// read and execute; divide and modulo also wait for the bit-serial divider. A write
// goes straight to the result; a read adds one memory read. One request at a time:
// in_stall holds off a new one until the last result is registered, which an output
// stall delays. Reset clears pc, flags, register file and pc/status/print cells and
// sets the stack tops to their bases; other memory words are undefined until written.
`default_nettype none
`include "risc16_instruction_execute_unit_macros.svh"
module risc16_instruction_execute_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] address,
    input  wire logic [15:0] write_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      read_data,
    output logic [15:0]      pc_value,
    output logic             halted,
    output logic [2:0]       fault_code,
    output logic             print_valid,
    output logic [15:0]      print_value
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_DEC  = 7'b0000100,
        S_OPR  = 7'b0001000,
        S_EXEC = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        SEL_MEM, SEL_PC, SEL_STATUS, SEL_PRINT
    } cell_sel_t;

    state_t      state_reg, state_next;
    cell_sel_t   sel_reg;
    logic [15:0] pc_reg, ds_reg, cs_reg;
    logic [3:0]  flags_reg;
    logic [15:0] pc_cell_reg, status_cell_reg, print_cell_reg;
    logic [1:0]  kind_reg;
    logic [15:0] ins_reg, x_reg, y_reg, m_reg, addr_reg;
    logic [2:0]  fault_reg;
    logic        halt_reg;

    logic        out_valid_reg, halted_reg, print_valid_reg;
    logic [15:0] read_data_reg, pc_value_reg, print_value_reg;
    logic [2:0]  fault_code_reg;

    risc16_pkg::mem_req_t mreq;
    risc16_pkg::rf_req_t  rreq;
    risc16_pkg::div_req_t dreq;
    risc16_pkg::div_rsp_t drsp;
    logic [15:0] mem_rdata, mrd, rf_rd0, rf_rd1;

    // unified write port: special cells live in flops, the rest in the RAM
    logic        wr_en;
    logic [15:0] wr_addr, wr_data;
    logic        rd_en;
    logic [15:0] rd_addr;

    logic        accept, out_free, exec_accept;
    logic [4:0]  op;
    logic [2:0]  ra, rb, rd;
    logic [15:0] rel, ldst_addr, pc_n, ds_n, cs_n;
    logic [3:0]  flags_n;
    logic [15:0] cmp_diff;
    logic [2:0]  fault_n;
    logic        halt_n, div_start;

    risc16_mem u_mem (
        .clk   (clk),
        .req   (mreq),
        .rdata (mem_rdata)
    );

    risc16_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (rreq),
        .rdata0 (rf_rd0),
        .rdata1 (rf_rd1)
    );

    risc16_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign accept      = in_valid && !in_stall;
    assign in_stall    = (state_reg != S_IDLE);
    assign out_free    = !out_valid_reg || !out_stall;
    assign exec_accept = accept && (opcode == risc16_pkg::KIND_EXEC);

    always_comb
    begin
        unique case (sel_reg)
            SEL_PC:     mrd = pc_cell_reg;
            SEL_STATUS: mrd = status_cell_reg;
            SEL_PRINT:  mrd = print_cell_reg;
            default:    mrd = mem_rdata;
        endcase
    end

    assign op  = ins_reg[15:11];
    assign ra  = ins_reg[10:8];
    assign rb  = ins_reg[7:5];
    assign rd  = ins_reg[4:2];
    assign rel = pc_reg + {{5{ins_reg[10]}}, ins_reg[10:0]};
    assign ldst_addr = (ins_reg[10] ? rf_rd0 : mrd) + (ins_reg[6] ? rf_rd1 : 16'd0);
    assign cmp_diff  = x_reg - y_reg;

    assign mreq.we    = wr_en && (wr_addr != risc16_pkg::PC_CELL)
                        && (wr_addr != risc16_pkg::STATUS_CELL)
                        && (wr_addr != risc16_pkg::PRINT_CELL);
    assign mreq.waddr = wr_addr;
    assign mreq.wdata = wr_data;
    assign mreq.raddr = rd_addr;

    always_comb
    begin
        state_next   = state_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        rreq.we      = 1'b0;
        rreq.waddr   = '0;
        rreq.wdata   = '0;
        rreq.raddr0  = '0;
        rreq.raddr1  = '0;
        pc_n         = pc_reg + 16'd1;
        ds_n         = ds_reg;
        cs_n         = cs_reg;
        flags_n      = flags_reg;
        fault_n      = risc16_pkg::FAULT_NONE;
        halt_n       = 1'b0;
        div_start    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        risc16_pkg::KIND_WRITE:
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = address;
                            wr_data    = write_data;
                            state_next = S_FIN;
                        end
                        risc16_pkg::KIND_READ:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = address;
                            state_next = S_RD;
                        end
                        risc16_pkg::KIND_EXEC:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = pc_reg;
                            state_next = S_DEC;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_FIN;
            end
            S_DEC:
            begin
                // mrd holds the instruction word
                rd_en = 1'b1;
                if (mrd[15:11] == risc16_pkg::OP_RET)
                begin
                    rd_addr = cs_reg + 16'd1;
                end
                else if (mrd[15:11] == risc16_pkg::OP_POP)
                begin
                    rd_addr = ds_reg + 16'd1;
                end
                else
                begin
                    rd_addr = pc_reg + 16'd1;
                end
                if (mrd[15:11] == risc16_pkg::OP_LD || mrd[15:11] == risc16_pkg::OP_ST)
                begin
                    rreq.raddr0 = mrd[2:0];
                    rreq.raddr1 = mrd[5:3];
                end
                else
                begin
                    rreq.raddr0 = mrd[10:8];
                    rreq.raddr1 = mrd[7:5];
                end
                state_next = S_OPR;
            end
            S_OPR:
            begin
                rd_en       = 1'b1;
                rd_addr     = ldst_addr;
                rreq.raddr0 = ins_reg[9:7];
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                case (op)
                    risc16_pkg::OP_LDI:
                    begin
                        rreq.we = 1'b1; rreq.waddr = ra; rreq.wdata = m_reg;
                        pc_n = pc_reg + 16'd2;
                    end
                    risc16_pkg::OP_LD:
                    begin
                        rreq.we = 1'b1; rreq.waddr = ins_reg[9:7]; rreq.wdata = mrd;
                        if (!ins_reg[10])
                        begin
                            pc_n = pc_reg + 16'd2;
                        end
                    end
                    risc16_pkg::OP_ST:
                    begin
                        wr_en = 1'b1; wr_addr = addr_reg; wr_data = rf_rd0;
                        if (!ins_reg[10])
                        begin
                            pc_n = pc_reg + 16'd2;
                        end
                    end
                    risc16_pkg::OP_CALL:
                    begin
                        pc_n = pc_reg + 16'd2;
                        if (cs_reg != risc16_pkg::CSTACK_LIMIT)
                        begin
                            wr_en = 1'b1; wr_addr = cs_reg; wr_data = pc_reg + 16'd2;
                            cs_n = cs_reg - 16'd1;
                            pc_n = m_reg;
                        end
                        else
                        begin
                            fault_n = risc16_pkg::FAULT_CS_OVF;
                        end
                    end
                    risc16_pkg::OP_RET:
                    begin
                        if (cs_reg != risc16_pkg::CSTACK_BASE)
                        begin
                            cs_n = cs_reg + 16'd1;
                            pc_n = m_reg;
                        end
                        else
                        begin
                            fault_n = risc16_pkg::FAULT_CS_UNF;
                        end
                    end
                    risc16_pkg::OP_PUSH:
                    begin
                        if (ds_reg != risc16_pkg::CSTACK_BASE)
                        begin
                            wr_en = 1'b1; wr_addr = ds_reg; wr_data = x_reg;
                            ds_n = ds_reg - 16'd1;
                        end
                        else
                        begin
                            fault_n = risc16_pkg::FAULT_DS_OVF;
                        end
                    end
                    risc16_pkg::OP_POP:
                    begin
                        if (ds_reg != risc16_pkg::DSTACK_BASE)
                        begin
                            ds_n = ds_reg + 16'd1;
                            rreq.we = 1'b1; rreq.waddr = ra; rreq.wdata = m_reg;
                        end
                        else
                        begin
                            fault_n = risc16_pkg::FAULT_DS_UNF;
                        end
                    end
                    risc16_pkg::OP_MOV:
                    begin
                        rreq.we = 1'b1; rreq.waddr = rb; rreq.wdata = x_reg;
                    end
                    risc16_pkg::OP_ADD,  risc16_pkg::OP_SUB,  risc16_pkg::OP_MUL,
                    risc16_pkg::OP_INC,  risc16_pkg::OP_DEC,  risc16_pkg::OP_SHL,
                    risc16_pkg::OP_SHR,  risc16_pkg::OP_AND,  risc16_pkg::OP_NAND,
                    risc16_pkg::OP_OR,   risc16_pkg::OP_NOR,  risc16_pkg::OP_XOR:
                    begin
                        rreq.we    = 1'b1;
                        rreq.waddr = rd;
                        case (op)
                            risc16_pkg::OP_ADD:  rreq.wdata = x_reg + y_reg;
                            risc16_pkg::OP_SUB:  rreq.wdata = cmp_diff;
                            risc16_pkg::OP_MUL:  rreq.wdata = x_reg * y_reg;
                            risc16_pkg::OP_INC:  rreq.wdata = x_reg + 16'd1;
                            risc16_pkg::OP_DEC:  rreq.wdata = x_reg - 16'd1;
                            risc16_pkg::OP_SHL:  rreq.wdata = {x_reg[14:0], 1'b0};
                            risc16_pkg::OP_SHR:  rreq.wdata = {1'b0, x_reg[15:1]};
                            risc16_pkg::OP_AND:  rreq.wdata = x_reg & y_reg;
                            risc16_pkg::OP_NAND: rreq.wdata = ~(x_reg & y_reg);
                            risc16_pkg::OP_OR:   rreq.wdata = x_reg | y_reg;
                            risc16_pkg::OP_NOR:  rreq.wdata = ~(x_reg | y_reg);
                            default:             rreq.wdata = x_reg ^ y_reg;
                        endcase
                    end
                    risc16_pkg::OP_DIV, risc16_pkg::OP_MOD:
                    begin
                        if (y_reg != 16'd0)
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        else
                        begin
                            fault_n = risc16_pkg::FAULT_DIV0;
                        end
                    end
                    risc16_pkg::OP_CMP:
                    begin
                        flags_n = {~cmp_diff[15], cmp_diff[15],
                                   cmp_diff != 16'd0, cmp_diff == 16'd0};
                    end
                    risc16_pkg::OP_JMP: pc_n = rel;
                    risc16_pkg::OP_JZ:  if (flags_reg[0]) pc_n = rel;
                    risc16_pkg::OP_JNZ: if (flags_reg[1]) pc_n = rel;
                    risc16_pkg::OP_JS:  if (flags_reg[2]) pc_n = rel;
                    risc16_pkg::OP_JNS: if (flags_reg[3]) pc_n = rel;
                    risc16_pkg::OP_HALT:
                    begin
                        halt_n = 1'b1;
                        pc_n   = pc_reg;
                    end
                    default:
                    begin
                    end
                endcase
                if (fault_n != risc16_pkg::FAULT_NONE)
                begin
                    wr_en   = 1'b1;
                    wr_addr = risc16_pkg::STATUS_CELL;
                    wr_data = {13'd0, fault_n};
                end
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    rreq.we    = 1'b1;
                    rreq.waddr = rd;
                    rreq.wdata = (op == risc16_pkg::OP_DIV) ? drsp.quo : drsp.rem;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (kind_reg == risc16_pkg::KIND_EXEC && print_cell_reg != 16'd0)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = risc16_pkg::PRINT_CELL;
                        wr_data = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign dreq.start    = div_start;
    assign dreq.dividend = x_reg;
    assign dreq.divisor  = y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sel_reg         <= SEL_MEM;
            pc_reg          <= '0;
            ds_reg          <= risc16_pkg::DSTACK_BASE;
            cs_reg          <= risc16_pkg::CSTACK_BASE;
            flags_reg       <= '0;
            pc_cell_reg     <= '0;
            status_cell_reg <= '0;
            print_cell_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rd_en)
            begin
                if (rd_addr == risc16_pkg::PC_CELL)
                begin
                    sel_reg <= SEL_PC;
                end
                else if (rd_addr == risc16_pkg::STATUS_CELL)
                begin
                    sel_reg <= SEL_STATUS;
                end
                else if (rd_addr == risc16_pkg::PRINT_CELL)
                begin
                    sel_reg <= SEL_PRINT;
                end
                else
                begin
                    sel_reg <= SEL_MEM;
                end
            end
            if (exec_accept)
            begin
                pc_cell_reg <= pc_reg;
            end
            if (wr_en && wr_addr == risc16_pkg::PC_CELL)
            begin
                pc_cell_reg <= wr_data;
            end
            if (wr_en && wr_addr == risc16_pkg::STATUS_CELL)
            begin
                status_cell_reg <= wr_data;
            end
            if (wr_en && wr_addr == risc16_pkg::PRINT_CELL)
            begin
                print_cell_reg <= wr_data;
            end
            if (state_reg == S_EXEC)
            begin
                pc_reg    <= pc_n;
                ds_reg    <= ds_n;
                cs_reg    <= cs_n;
                flags_reg <= flags_n;
            end
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= opcode;
            fault_reg <= risc16_pkg::FAULT_NONE;
            halt_reg  <= 1'b0;
        end
        if (state_reg == S_RD)
        begin
            m_reg <= mrd;
        end
        if (state_reg == S_DEC)
        begin
            ins_reg <= mrd;
        end
        if (state_reg == S_OPR)
        begin
            x_reg    <= rf_rd0;
            y_reg    <= rf_rd1;
            m_reg    <= mrd;
            addr_reg <= ldst_addr;
        end
        if (state_reg == S_EXEC)
        begin
            fault_reg <= fault_n;
            halt_reg  <= halt_n;
        end
        if (state_reg == S_FIN && out_free)
        begin
            read_data_reg   <= (kind_reg == risc16_pkg::KIND_READ) ? m_reg : 16'd0;
            pc_value_reg    <= pc_reg;
            halted_reg      <= (kind_reg == risc16_pkg::KIND_EXEC) && halt_reg;
            fault_code_reg  <= (kind_reg == risc16_pkg::KIND_EXEC) ? fault_reg
                                                                 : risc16_pkg::FAULT_NONE;
            print_valid_reg <= (kind_reg == risc16_pkg::KIND_EXEC) && (print_cell_reg != 16'd0);
            print_value_reg <= (kind_reg == risc16_pkg::KIND_EXEC) ? print_cell_reg : 16'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign pc_value    = pc_value_reg;
    assign halted      = halted_reg;
    assign fault_code  = fault_code_reg;
    assign print_valid = print_valid_reg;
    assign print_value = print_value_reg;

    `R16_ASSERT_IMP(a_div_busy, (state_reg == S_DIV) && !drsp.done, drsp.busy)
    `R16_ASSERT_NXT(a_accept_leaves_idle, in_valid && !in_stall, state_reg != S_IDLE)
    `R16_ASSERT_IMP(a_halt_no_fault, out_valid && halted, fault_code == risc16_pkg::FAULT_NONE)
endmodule
`default_nettype wire
